// File: design/projective_point_transform_2d_defines.svh
// assertion macros for the projective point transform
`ifndef PROJECTIVE_POINT_TRANSFORM_2D_DEFINES_SVH
`define PROJECTIVE_POINT_TRANSFORM_2D_DEFINES_SVH
`ifndef SYNTHESIS
`define PPT2D_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define PPT2D_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define PPT2D_ASSERT(lbl, prop, msg)
`define PPT2D_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: design/ppt2d_pkg.sv
// types and constants of the projective point transform
package ppt2d_pkg;

    localparam int CW            = 32;
    localparam int LW            = 2 * CW + 2;
    localparam int QW            = CW;
    localparam int NL            = 4;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IW        = 3;

    localparam logic [2:0] KIND_IDENT = 3'd0;
    localparam logic [2:0] KIND_TRANS = 3'd1;
    localparam logic [2:0] KIND_SCALE = 3'd2;
    localparam logic [2:0] KIND_ROT   = 3'd3;
    localparam logic [2:0] KIND_AFF   = 3'd4;
    localparam logic [2:0] KIND_PROJ  = 3'd5;

    localparam logic [CFG_IW-1:0] REG_KIND  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_ROW0  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_ROW1  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_OFF   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_PERSP = 3'd4;
    localparam logic [CFG_IW-1:0] REG_BIAS  = 3'd5;
    localparam logic [CFG_IW-1:0] REG_MIND  = 3'd6;

    typedef struct packed {
        logic [LW-1:0] rem;
        logic [LW-1:0] un;
        logic [LW-1:0] uw;
        logic [QW-1:0] q;
        logic          neg;
        logic          ovf;
    } div_lane_t;

    typedef struct packed {
        logic                 last;
        logic                 proj;
        logic                 vec;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
    } side_t;

endpackage

// File: design/projective_point_transform_2d.sv
// projective point transform: 2d point or vector through a 3x3 q-format matrix
// usage:
// - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the seven registers;
//   cfg_ready is always high; writes must go in only while the block is idle, which the block itself does not enforce
// - s_ channel takes one word per cycle while s_ready is high (operation, in_x, in_y, in_last)
// - m_ channel returns one word per input word, in order
// - every word passes all pipeline stages from acceptance to m_valid; one word per
//   cycle sustained while m_ready is high; most stages are the 32 restoring division
//   steps that produce the quotient bits of the projection divide, one bit per stage
// - kinds other than projection take the same path and the same latency
// - reset loads identity coefficients and empties the pipeline
// - when m_ready is low, words close up behind the output register and
//   s_ready drops only once every stage holds a word; nothing is lost
`include "projective_point_transform_2d_defines.svh"
module projective_point_transform_2d
    import ppt2d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IW-1:0]    cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_operation,
    input  logic signed [CW-1:0] s_in_x,
    input  logic signed [CW-1:0] s_in_y,
    input  logic                 s_in_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [CW-1:0] m_out_x,
    output logic signed [CW-1:0] m_out_y,
    output logic                 m_out_last
);

    localparam int NS = QW + 5;
    localparam int SH = CW - FRAC_BITS;
    localparam logic signed [64:0] HALF = 65'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [CW-1:0] MAX32 = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MIN32 = {1'b1, {(CW-1){1'b0}}};

    // configuration registers
    logic [2:0]           kind_reg;
    logic [63:0]          row0_reg, row1_reg, off_reg, persp_reg;
    logic signed [CW-1:0] bias_reg;
    logic [30:0]          mind_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg  <= KIND_IDENT;
            row0_reg  <= 64'd1 << FRAC_BITS;
            row1_reg  <= 64'd1 << (32 + FRAC_BITS);
            off_reg   <= '0;
            persp_reg <= '0;
            bias_reg  <= 32'sd1 <<< FRAC_BITS;
            mind_reg  <= 31'd1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_KIND:  kind_reg  <= cfg_data[2:0];
                REG_ROW0:  row0_reg  <= cfg_data;
                REG_ROW1:  row1_reg  <= cfg_data;
                REG_OFF:   off_reg   <= cfg_data;
                REG_PERSP: persp_reg <= cfg_data;
                REG_BIAS:  bias_reg  <= signed'(cfg_data[31:0]);
                REG_MIND:  mind_reg  <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    logic signed [CW-1:0] m00, m01, m10, m11, m20, m21, m02, m12;
    logic [30:0]          min_eff;

    assign m00 = signed'(row0_reg[31:0]);
    assign m01 = signed'(row0_reg[63:32]);
    assign m10 = signed'(row1_reg[31:0]);
    assign m11 = signed'(row1_reg[63:32]);
    assign m20 = signed'(off_reg[31:0]);
    assign m21 = signed'(off_reg[63:32]);
    assign m02 = signed'(persp_reg[31:0]);
    assign m12 = signed'(persp_reg[63:32]);
    assign min_eff = (mind_reg == '0) ? 31'd1 : mind_reg;

    function automatic logic signed [64:0] rnd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b) + HALF;
        return s >>> FRAC_BITS;
    endfunction

    function automatic logic signed [CW-1:0] sat32(input logic signed [LW-1:0] v);
        if ((&v[LW-1:CW-1]) || !(|v[LW-1:CW-1])) begin
            return v[CW-1:0];
        end
        return v[LW-1] ? MIN32 : MAX32;
    endfunction

    function automatic logic signed [LW-1:0] clampw(input logic signed [LW-1:0] w,
                                                    input logic [30:0] m);
        logic signed [LW-1:0] ms;
        ms = signed'(LW'(m));
        if (!w[LW-1]) begin
            return (w < ms) ? ms : w;
        end
        return (-w < ms) ? -ms : w;
    endfunction

    function automatic logic [LW-1:0] mag(input logic signed [LW-1:0] v);
        return v[LW-1] ? LW'(-v) : LW'(v);
    endfunction

    function automatic div_lane_t mk_lane(input logic signed [LW-1:0] n,
                                          input logic signed [LW-1:0] w);
        div_lane_t l;
        l.un  = mag(n);
        l.uw  = mag(w);
        l.neg = n[LW-1] ^ w[LW-1];
        l.rem = l.un >> SH;
        l.ovf = (l.rem >= l.uw);
        l.q   = '0;
        return l;
    endfunction

    function automatic logic signed [CW-1:0] fin(input div_lane_t l);
        if (l.ovf || l.q[QW-1]) begin
            return l.neg ? MIN32 : MAX32;
        end
        return l.neg ? -signed'(l.q) : signed'(l.q);
    endfunction

    // pipeline handshake: a stage loads when it is empty or its word moves on
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] rdy;

    always_comb begin
        rdy[NS-1] = !vld_reg[NS-1] || m_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign s_ready = rdy[0];

    // stage 0: input register
    logic                 op0_reg, last0_reg;
    logic signed [CW-1:0] x0_reg, y0_reg;

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            op0_reg   <= s_operation;
            last0_reg <= s_in_last;
            x0_reg    <= s_in_x;
            y0_reg    <= s_in_y;
        end
    end

    // stage 1: products
    logic                 op1_reg, last1_reg;
    logic signed [CW-1:0] x1_reg, y1_reg;
    logic signed [63:0]   pxm00_reg, pym10_reg, pxm01_reg, pym11_reg, pxm02_reg, pym12_reg;

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            op1_reg   <= op0_reg;
            last1_reg <= last0_reg;
            x1_reg    <= x0_reg;
            y1_reg    <= y0_reg;
            pxm00_reg <= x0_reg * m00;
            pym10_reg <= y0_reg * m10;
            pxm01_reg <= x0_reg * m01;
            pym11_reg <= y0_reg * m11;
            pxm02_reg <= x0_reg * m02;
            pym12_reg <= y0_reg * m12;
        end
    end

    // stage 2: rounded sums plus offsets
    logic                 op2_reg, last2_reg;
    logic signed [CW-1:0] x2_reg, y2_reg;
    logic signed [LW-1:0] lx2_reg, ly2_reg, lw2_reg;
    logic signed [LW-1:0] lx2_next, ly2_next, lw2_next;
    logic signed [63:0]   pb_x, pa_y;
    logic signed [CW-1:0] offx, offy;
    logic                 use_off;

    always_comb begin
        pb_x     = (kind_reg == KIND_SCALE) ? '0 : pym10_reg;
        pa_y     = (kind_reg == KIND_SCALE) ? '0 : pxm01_reg;
        use_off  = (kind_reg == KIND_PROJ) || !op1_reg;
        offx     = use_off ? m20 : '0;
        offy     = use_off ? m21 : '0;
        lx2_next = LW'(rnd(pxm00_reg, pb_x)) + LW'(offx);
        ly2_next = LW'(rnd(pa_y, pym11_reg)) + LW'(offy);
        lw2_next = LW'(rnd(pxm02_reg, pym12_reg)) + LW'(bias_reg);
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            op2_reg   <= op1_reg;
            last2_reg <= last1_reg;
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            lx2_reg   <= lx2_next;
            ly2_reg   <= ly2_next;
            lw2_reg   <= lw2_next;
        end
    end

    // stage 3: clamp denominator, split sign and magnitude, direct results
    div_lane_t dl_reg [QW+1][NL];
    side_t     sd_reg [QW+1];

    logic signed [LW-1:0] wc, w0c;
    side_t                sd_next;

    always_comb begin
        wc  = clampw(lw2_reg, min_eff);
        w0c = clampw(LW'(bias_reg), min_eff);
        sd_next.last = last2_reg;
        sd_next.proj = (kind_reg == KIND_PROJ);
        sd_next.vec  = op2_reg;
        case (kind_reg)
            KIND_TRANS: begin
                sd_next.bx = op2_reg ? x2_reg : sat32(LW'(x2_reg) + LW'(m20));
                sd_next.by = op2_reg ? y2_reg : sat32(LW'(y2_reg) + LW'(m21));
            end
            KIND_SCALE, KIND_ROT, KIND_AFF: begin
                sd_next.bx = sat32(lx2_reg);
                sd_next.by = sat32(ly2_reg);
            end
            default: begin
                sd_next.bx = x2_reg;
                sd_next.by = y2_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            dl_reg[0][0] <= mk_lane(lx2_reg, wc);
            dl_reg[0][1] <= mk_lane(ly2_reg, wc);
            dl_reg[0][2] <= mk_lane(LW'(m20), w0c);
            dl_reg[0][3] <= mk_lane(LW'(m21), w0c);
            sd_reg[0]    <= sd_next;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar s = 0; s < QW; s++) begin : g_div
        localparam int J = QW - 1 - s;
        for (genvar ln = 0; ln < NL; ln++) begin : g_lane
            logic      nb;
            logic [LW:0] t, d;
            div_lane_t nx;
            if (J >= FRAC_BITS) begin : g_bit
                assign nb = dl_reg[s][ln].un[J-FRAC_BITS];
            end else begin : g_zero
                assign nb = 1'b0;
            end
            always_comb begin
                nx = dl_reg[s][ln];
                t  = {dl_reg[s][ln].rem, nb};
                d  = t - {1'b0, dl_reg[s][ln].uw};
                if (!d[LW]) begin
                    nx.rem  = d[LW-1:0];
                    nx.q[J] = 1'b1;
                end else begin
                    nx.rem = t[LW-1:0];
                end
            end
            always_ff @(posedge aclk) begin
                if (rdy[4+s]) begin
                    dl_reg[s+1][ln] <= nx;
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (rdy[4+s]) begin
                sd_reg[s+1] <= sd_reg[s];
            end
        end
    end

    // output stage: signs, saturation, origin term for vectors
    logic signed [CW-1:0] dx, dy, d0x, d0y, rx, ry;
    logic signed [CW-1:0] m_x_reg, m_y_reg;
    logic                 m_last_reg;

    always_comb begin
        dx  = fin(dl_reg[QW][0]);
        dy  = fin(dl_reg[QW][1]);
        d0x = fin(dl_reg[QW][2]);
        d0y = fin(dl_reg[QW][3]);
        if (sd_reg[QW].proj) begin
            rx = sd_reg[QW].vec ? sat32(LW'(dx) - LW'(d0x)) : dx;
            ry = sd_reg[QW].vec ? sat32(LW'(dy) - LW'(d0y)) : dy;
        end else begin
            rx = sd_reg[QW].bx;
            ry = sd_reg[QW].by;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[NS-1]) begin
            m_x_reg    <= rx;
            m_y_reg    <= ry;
            m_last_reg <= sd_reg[QW].last;
        end
    end

    assign m_valid    = vld_reg[NS-1];
    assign m_out_x    = m_x_reg;
    assign m_out_y    = m_y_reg;
    assign m_out_last = m_last_reg;

    `PPT2D_ASSERT(a_rem_bound, vld_reg[NS-2] && !dl_reg[QW][0].ovf |-> dl_reg[QW][0].rem < dl_reg[QW][0].uw, "division remainder not below divisor")
    `PPT2D_ASSERT_NEVER(a_zero_den, vld_reg[3] && sd_reg[0].proj && (dl_reg[0][0].uw == '0), "zero denominator after clamp")
    `PPT2D_ASSERT(a_out_load, vld_reg[NS-2] && rdy[NS-1] |=> m_valid, "word lost before output register")

endmodule
